/* rtl/sscr_pkg.sv */
// Shared types and constants for the segment/sphere crossing test.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sscr_pkg;

  localparam int unsigned CoordBitsDefault = 16;
  localparam int unsigned QueueDepth       = 4;

  typedef enum logic [1:0] {
    OUT_ZERO    = 2'd0,  // zero-length segment
    OUT_MISS    = 2'd1,  // line misses the sphere
    OUT_OUTSIDE = 2'd2,  // crossings lie outside the segment
    OUT_HIT     = 2'd3
  } sscr_outcome_e;

  // classification handed from the front to the back
  typedef struct packed {
    sscr_outcome_e tent;       // outcome if the discriminant is non-negative
    logic          need_disc;  // start point outside: discriminant decides
  } sscr_cls_t;

endpackage

/* rtl/sscr_front.sv */
// Front part: differences, products, quadratic terms and classification.
// Depends on sscr_pkg. Three pipeline stages, feeds the queue.
`timescale 1ns / 1ps

module sscr_front #(
  parameter int unsigned COORD_BITS = sscr_pkg::CoordBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [COORD_BITS-1:0]         start_x_i,
  input  logic [COORD_BITS-1:0]         start_y_i,
  input  logic [COORD_BITS-1:0]         start_z_i,
  input  logic [COORD_BITS-1:0]         end_x_i,
  input  logic [COORD_BITS-1:0]         end_y_i,
  input  logic [COORD_BITS-1:0]         end_z_i,
  input  logic [COORD_BITS-1:0]         center_x_i,
  input  logic [COORD_BITS-1:0]         center_y_i,
  input  logic [COORD_BITS-1:0]         center_z_i,
  input  logic [COORD_BITS-1:0]         sphere_radius_i,
  output logic                          push_o,
  input  logic                          full_i,
  output sscr_pkg::sscr_cls_t           cls_o,
  output logic [2*COORD_BITS+1:0]       mag_h_o,
  output logic [2*COORD_BITS+1:0]       a_o,
  output logic [2*COORD_BITS+1:0]       f0_o
);
  import sscr_pkg::*;

  localparam int unsigned N  = COORD_BITS;
  localparam int unsigned OW = 2 * N + 2;
  localparam int unsigned SW = 2 * N + 4;

  logic free1, free2, free3;
  logic s1_vld_q, s2_vld_q, s3_vld_q;

  assign free3   = ~s3_vld_q | ~full_i;
  assign free2   = ~s2_vld_q | free3;
  assign free1   = ~s1_vld_q | free2;
  assign stall_o = ~free1;
  assign push_o  = s3_vld_q & ~full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      if (free1) s1_vld_q <= valid_i;
      if (free2) s2_vld_q <= s1_vld_q;
      if (free3) s3_vld_q <= s2_vld_q;
    end
  end

  // stage 1: differences
  logic signed [N:0] dx_q, dy_q, dz_q, wx_q, wy_q, wz_q, vx_q, vy_q, vz_q;
  logic [N-1:0]      r_q;

  function automatic logic signed [N:0] sdiff(input logic [N-1:0] p, input logic [N-1:0] q);
    sdiff = $signed({p[N-1], p}) - $signed({q[N-1], q});
  endfunction

  always_ff @(posedge clk_i) begin
    if (free1 && valid_i) begin
      dx_q <= sdiff(end_x_i, start_x_i);
      dy_q <= sdiff(end_y_i, start_y_i);
      dz_q <= sdiff(end_z_i, start_z_i);
      wx_q <= sdiff(start_x_i, center_x_i);
      wy_q <= sdiff(start_y_i, center_y_i);
      wz_q <= sdiff(start_z_i, center_z_i);
      vx_q <= sdiff(end_x_i, center_x_i);
      vy_q <= sdiff(end_y_i, center_y_i);
      vz_q <= sdiff(end_z_i, center_z_i);
      r_q  <= sphere_radius_i;
    end
  end

  // stage 2: products, one per lane
  logic signed [2*N+1:0] dd_x_q, dd_y_q, dd_z_q, wd_x_q, wd_y_q, wd_z_q;
  logic signed [2*N+1:0] ww_x_q, ww_y_q, ww_z_q, vv_x_q, vv_y_q, vv_z_q;
  logic [2*N-1:0]        rr_q;

  always_ff @(posedge clk_i) begin
    if (free2 && s1_vld_q) begin
      dd_x_q <= dx_q * dx_q;
      dd_y_q <= dy_q * dy_q;
      dd_z_q <= dz_q * dz_q;
      wd_x_q <= wx_q * dx_q;
      wd_y_q <= wy_q * dy_q;
      wd_z_q <= wz_q * dz_q;
      ww_x_q <= wx_q * wx_q;
      ww_y_q <= wy_q * wy_q;
      ww_z_q <= wz_q * wz_q;
      vv_x_q <= vx_q * vx_q;
      vv_y_q <= vy_q * vy_q;
      vv_z_q <= vz_q * vz_q;
      rr_q   <= r_q * r_q;
    end
  end

  // stage 3: quadratic terms, f0/f1 are the surface function at both ends
  logic signed [SW-1:0] a_q, h_q, f0_q, f1_q;
  logic signed [SW-1:0] rr_ext;

  assign rr_ext = $signed(SW'(rr_q));

  always_ff @(posedge clk_i) begin
    if (free3 && s2_vld_q) begin
      a_q  <= SW'(dd_x_q) + SW'(dd_y_q) + SW'(dd_z_q);
      h_q  <= SW'(wd_x_q) + SW'(wd_y_q) + SW'(wd_z_q);
      f0_q <= SW'(ww_x_q) + SW'(ww_y_q) + SW'(ww_z_q) - rr_ext;
      f1_q <= SW'(vv_x_q) + SW'(vv_y_q) + SW'(vv_z_q) - rr_ext;
    end
  end

  // classification on the stage 3 registers
  logic signed [SW-1:0] neg_h;
  logic                 zero_len, f0_neg, f1_neg, f0_zero, f1_zero, vertex_in;

  always_comb begin
    neg_h     = -h_q;
    zero_len  = (a_q == '0);
    f0_neg    = f0_q[SW-1];
    f1_neg    = f1_q[SW-1];
    f0_zero   = (f0_q == '0);
    f1_zero   = (f1_q == '0);
    // both ends outside: hit when the closest point falls inside (0,1)
    vertex_in = h_q[SW-1] && (neg_h < a_q);

    cls_o.need_disc = ~zero_len & ~f0_neg & ~f0_zero;
    if (zero_len)                cls_o.tent = OUT_ZERO;
    else if (f0_zero || f1_zero) cls_o.tent = OUT_HIT;
    else if (f0_neg != f1_neg)   cls_o.tent = OUT_HIT;
    else if (f0_neg)             cls_o.tent = OUT_OUTSIDE;
    else if (vertex_in)          cls_o.tent = OUT_HIT;
    else                         cls_o.tent = OUT_OUTSIDE;

    mag_h_o = h_q[SW-1] ? neg_h[OW-1:0] : h_q[OW-1:0];
    a_o     = a_q[OW-1:0];
    f0_o    = f0_q[OW-1:0];
  end

endmodule

/* rtl/sscr_fifo.sv */
// Short queue between the front and the back parts.
// Depends on sscr_pkg for the default depth.
`timescale 1ns / 1ps

module sscr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = sscr_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  import sscr_pkg::*;

  localparam int unsigned PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CB = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PB-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CB-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CB'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  function automatic logic [PB-1:0] nxt(input logic [PB-1:0] p);
    nxt = (p == PB'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= nxt(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= nxt(rd_ptr_q);
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CB'(DEPTH)) else $error("queue count above depth");
  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow on push");
  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into a full queue");

endmodule

/* rtl/sscr_back.sv */
// Back part: discriminant check h^2 >= a*c by split partial products.
// Depends on sscr_pkg. Two stages plus the output register.
`timescale 1ns / 1ps

module sscr_back #(
  parameter int unsigned COORD_BITS = sscr_pkg::CoordBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    empty_i,
  output logic                    pop_o,
  input  sscr_pkg::sscr_cls_t     cls_i,
  input  logic [2*COORD_BITS+1:0] mag_h_i,
  input  logic [2*COORD_BITS+1:0] a_i,
  input  logic [2*COORD_BITS+1:0] f0_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic                    hit_o,
  output logic [1:0]              outcome_o
);
  import sscr_pkg::*;

  localparam int unsigned H  = COORD_BITS + 1;
  localparam int unsigned OW = 2 * H;
  localparam int unsigned PW = 2 * OW;

  logic b1_vld_q, b2_vld_q, out_vld_q;
  logic free_o, free2, free1;

  assign free_o = ~out_vld_q | ~stall_i;
  assign free2  = ~b2_vld_q | free_o;
  assign free1  = ~b1_vld_q | free2;
  assign pop_o  = ~empty_i & free1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q  <= 1'b0;
      b2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (free1)  b1_vld_q  <= ~empty_i;
      if (free2)  b2_vld_q  <= b1_vld_q;
      if (free_o) out_vld_q <= b2_vld_q;
    end
  end

  // stage 1: partial products of halves
  logic [OW-1:0] hh_ll_q, hh_lh_q, hh_hh_q;
  logic [OW-1:0] af_ll_q, af_lh_q, af_hl_q, af_hh_q;
  sscr_cls_t     cls1_q, cls2_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      hh_ll_q <= mag_h_i[H-1:0]  * mag_h_i[H-1:0];
      hh_lh_q <= mag_h_i[H-1:0]  * mag_h_i[OW-1:H];
      hh_hh_q <= mag_h_i[OW-1:H] * mag_h_i[OW-1:H];
      af_ll_q <= a_i[H-1:0]  * f0_i[H-1:0];
      af_lh_q <= a_i[H-1:0]  * f0_i[OW-1:H];
      af_hl_q <= a_i[OW-1:H] * f0_i[H-1:0];
      af_hh_q <= a_i[OW-1:H] * f0_i[OW-1:H];
      cls1_q  <= cls_i;
    end
  end

  // stage 2: assemble the full products
  logic [PW-1:0] hsq_q, af_q;

  always_ff @(posedge clk_i) begin
    if (free2 && b1_vld_q) begin
      hsq_q  <= PW'(hh_ll_q) + (PW'(hh_lh_q) << (H + 1)) + (PW'(hh_hh_q) << OW);
      af_q   <= PW'(af_ll_q) + ((PW'(af_lh_q) + PW'(af_hl_q)) << H)
              + (PW'(af_hh_q) << OW);
      cls2_q <= cls1_q;
    end
  end

  // output register
  sscr_outcome_e outc_d, outc_q;

  always_comb begin
    outc_d = cls2_q.tent;
    if (cls2_q.need_disc && (hsq_q < af_q)) outc_d = OUT_MISS;
  end

  always_ff @(posedge clk_i) begin
    if (free_o && b2_vld_q) outc_q <= outc_d;
  end

  assign valid_o   = out_vld_q;
  assign outcome_o = outc_q;
  assign hit_o     = (outc_q == OUT_HIT);

endmodule

/* rtl/segment_sphere_crossing_test.sv */
// Segment versus sphere crossing test, top level.
// Depends on sscr_pkg, sscr_front, sscr_fifo and sscr_back.
//
// Usage:
//   Input channel: valid_i / stall_o with the segment start and end points,
//   the sphere center and radius. A beat is taken at a clock edge with
//   valid_i high and stall_o low.
//   Output channel: valid_o / stall_i with hit_o and outcome_o, one result
//   beat for every input beat, in order.
//   Path: each input beat passes three front stages, the queue, two back
//   stages and the output register.
//   Throughput: one beat per cycle while stall_i is low, set by the fully
//   pipelined multiplier lanes in the front and the split partial products
//   in the back. The four-entry queue between front and back lets the back
//   stall while the front keeps taking beats; stall_o rises once the queue
//   and the front stages have filled.
//   Reset: rst_ni clears all valid flags and queue pointers; no results
//   are pending afterwards and the block accepts beats at once.
`timescale 1ns / 1ps

module segment_sphere_crossing_test #(
  parameter int unsigned COORD_BITS = sscr_pkg::CoordBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] start_z_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic [COORD_BITS-1:0] end_z_i,
  input  logic [COORD_BITS-1:0] center_x_i,
  input  logic [COORD_BITS-1:0] center_y_i,
  input  logic [COORD_BITS-1:0] center_z_i,
  input  logic [COORD_BITS-1:0] sphere_radius_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic                  hit_o,
  output logic [1:0]            outcome_o
);
  import sscr_pkg::*;

  localparam int unsigned OW = 2 * COORD_BITS + 2;
  localparam int unsigned QW = $bits(sscr_cls_t) + 3 * OW;

  logic          push, full, pop, empty;
  sscr_cls_t     f_cls, b_cls;
  logic [OW-1:0] f_mag_h, f_a, f_f0, b_mag_h, b_a, b_f0;
  logic [QW-1:0] q_wdata, q_rdata;

  sscr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .start_x_i, .start_y_i, .start_z_i,
    .end_x_i, .end_y_i, .end_z_i,
    .center_x_i, .center_y_i, .center_z_i,
    .sphere_radius_i,
    .push_o  (push),
    .full_i  (full),
    .cls_o   (f_cls),
    .mag_h_o (f_mag_h),
    .a_o     (f_a),
    .f0_o    (f_f0)
  );

  assign q_wdata = {f_cls, f_mag_h, f_a, f_f0};

  sscr_fifo #(.WIDTH(QW), .DEPTH(QueueDepth)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .empty_o (empty)
  );

  assign {b_cls, b_mag_h, b_a, b_f0} = q_rdata;

  sscr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i, .rst_ni,
    .empty_i (empty),
    .pop_o   (pop),
    .cls_i   (b_cls),
    .mag_h_i (b_mag_h),
    .a_i     (b_a),
    .f0_i    (b_f0),
    .valid_o, .stall_i, .hit_o, .outcome_o
  );

endmodule

/* bench/segment_sphere_crossing_test_test.sv */
// Self-checking bench for segment_sphere_crossing_test: random and directed
// segment/sphere pairs, exact integer prediction, in-order result check.
// Depends on sscr_pkg and the block RTL.
`timescale 1ns / 1ps

module segment_sphere_crossing_test_test;
  import sscr_pkg::*;

  localparam int CB = 16;
  localparam int QUIET_LIMIT = 20000;

  typedef struct packed {
    logic [CB-1:0] sx, sy, sz, ex, ey, ez, cx, cy, cz, rad;
  } query_t;

  typedef struct packed {
    logic          hit;
    sscr_outcome_e outcome;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic stall_o, valid_o, hit_o;
  logic [1:0] outcome_o;
  query_t cur = '0;

  query_t   pending_q[$];
  verdict_t verdicts_q[$];
  int errors = 0;
  int hits_seen = 0;
  int results_seen = 0;
  int quiet = 0;
  int gap = 0;
  int hold_off = 0;
  bit stim_done = 1'b0;
  bit drain_wait = 1'b0;
  int sent = 0;
  int cnt[4] = '{0, 0, 0, 0};

  always #10 clk_i = ~clk_i;

  segment_sphere_crossing_test #(.COORD_BITS(CB)) DUT (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .start_x_i(cur.sx), .start_y_i(cur.sy), .start_z_i(cur.sz),
    .end_x_i(cur.ex), .end_y_i(cur.ey), .end_z_i(cur.ez),
    .center_x_i(cur.cx), .center_y_i(cur.cy), .center_z_i(cur.cz),
    .sphere_radius_i(cur.rad),
    .valid_o, .stall_i, .hit_o, .outcome_o
  );

  function automatic verdict_t classify_crossing(query_t q);
    longint dx, dy, dz, wx, wy, wz, vx, vy, vz, a, h, rr, f0, f1;
    logic signed [127:0] disc_l, disc_r;
    sscr_outcome_e o;
    verdict_t v;
    dx = longint'($signed(q.ex)) - longint'($signed(q.sx));
    dy = longint'($signed(q.ey)) - longint'($signed(q.sy));
    dz = longint'($signed(q.ez)) - longint'($signed(q.sz));
    wx = longint'($signed(q.sx)) - longint'($signed(q.cx));
    wy = longint'($signed(q.sy)) - longint'($signed(q.cy));
    wz = longint'($signed(q.sz)) - longint'($signed(q.cz));
    vx = longint'($signed(q.ex)) - longint'($signed(q.cx));
    vy = longint'($signed(q.ey)) - longint'($signed(q.cy));
    vz = longint'($signed(q.ez)) - longint'($signed(q.cz));
    a = dx * dx + dy * dy + dz * dz;
    h = wx * dx + wy * dy + wz * dz;
    rr = longint'({48'd0, q.rad}) * longint'({48'd0, q.rad});
    f0 = wx * wx + wy * wy + wz * wz - rr;
    f1 = vx * vx + vy * vy + vz * vz - rr;
    disc_l = 128'(h) * 128'(h);
    disc_r = 128'(a) * 128'(f0);
    if (a == 0) o = OUT_ZERO;
    else if (f0 > 0 && disc_l < disc_r) o = OUT_MISS;
    else if (f0 == 0 || f1 == 0) o = OUT_HIT;
    else if ((f0 < 0) != (f1 < 0)) o = OUT_HIT;
    else if (f0 < 0) o = OUT_OUTSIDE;
    else if (h < 0 && -h < a) o = OUT_HIT;
    else o = OUT_OUTSIDE;
    v.outcome = o;
    v.hit = (o == OUT_HIT);
    return v;
  endfunction

  function automatic logic [CB-1:0] rnd_coord(int span);
    case ($urandom_range(0, 5))
      0: return CB'($urandom);
      1: return ($urandom_range(0, 1)) ? 16'h8000 : 16'h7fff;
      default: return CB'($urandom_range(0, 2 * span) - span);
    endcase
  endfunction

  function automatic query_t make_query();
    query_t q;
    int span;
    span = ($urandom_range(0, 3) == 0) ? 30000 : 200;
    q.sx = rnd_coord(span); q.sy = rnd_coord(span); q.sz = rnd_coord(span);
    q.cx = rnd_coord(span); q.cy = rnd_coord(span); q.cz = rnd_coord(span);
    if ($urandom_range(0, 9) == 0) {q.ex, q.ey, q.ez} = {q.sx, q.sy, q.sz};
    else begin
      q.ex = rnd_coord(span); q.ey = rnd_coord(span); q.ez = rnd_coord(span);
    end
    case ($urandom_range(0, 3))
      0: q.rad = CB'($urandom);
      1: q.rad = ($urandom_range(0, 1)) ? 16'hffff : 16'h0000;
      default: q.rad = CB'($urandom_range(0, 3 * span));
    endcase
    return q;
  endfunction

  function automatic query_t mk(int sx, sy, sz, ex, ey, ez, cx, cy, cz, r);
    query_t q;
    q = {CB'(sx), CB'(sy), CB'(sz), CB'(ex), CB'(ey), CB'(ez),
         CB'(cx), CB'(cy), CB'(cz), CB'(r)};
    return q;
  endfunction

  // directed cases then random fill; a drain pause sits in the middle
  initial begin
    pending_q.push_back(mk(5, 5, 5, 5, 5, 5, 0, 0, 0, 3));          // zero length
    pending_q.push_back(mk(-10, 20, 0, 10, 20, 0, 0, 0, 0, 5));     // miss
    pending_q.push_back(mk(-10, 5, 0, 10, 5, 0, 0, 0, 0, 5));       // tangent
    pending_q.push_back(mk(-1, 0, 0, 1, 0, 0, 0, 0, 0, 5));         // inside
    pending_q.push_back(mk(5, 0, 0, 20, 0, 0, 0, 0, 0, 5));         // start on surface
    pending_q.push_back(mk(20, 0, 0, 5, 0, 0, 0, 0, 0, 5));
    pending_q.push_back(mk(0, 0, 0, 20, 0, 0, 0, 0, 0, 5));         // crosses out
    pending_q.push_back(mk(-20, 0, 0, 20, 0, 0, 0, 0, 0, 5));       // through
    pending_q.push_back(mk(10, 0, 0, 30, 0, 0, 0, 0, 0, 5));        // beyond end
    pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                           32767, -32768, 32767, 65535));
    pending_q.push_back(mk(32767, 32767, 32767, -32768, -32768, -32768,
                           -32768, 32767, -32768, 0));
    pending_q.push_back(mk(-32768, 0, 0, 32767, 0, 0, 0, 0, 0, 65535));
    pending_q.push_back(mk(-32768, -32768, -32768, -32767, -32768, -32768,
                           32767, 32767, 32767, 65535));
    pending_q.push_back(mk(3, 4, 0, 3, 4, 9, 0, 0, 0, 5));          // start on surface
    for (int i = 0; i < 600; i++) pending_q.push_back(make_query());
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        exp_v = classify_crossing(cur);
        cnt[exp_v.outcome]++;
        verdicts_q.push_back(exp_v);
        sent++;
      end
      if (!(valid_i && stall_o)) begin
        if (drain_wait) begin
          valid_i <= 1'b0;
          if (verdicts_q.size() == 0 && !(valid_i && !stall_o)) drain_wait <= 1'b0;
        end else if (sent == 300 && valid_i && !stall_o) begin
          valid_i <= 1'b0;
          drain_wait <= 1'b1;
        end else if (gap > 0) begin
          valid_i <= 1'b0;
          gap <= gap - 1;
        end else if (pending_q.size() > 0) begin
          cur <= pending_q.pop_front();
          valid_i <= 1'b1;
          if ($urandom_range(0, 3) == 0)
            gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                 : $urandom_range(1, 2);
        end else begin
          valid_i <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        results_seen++;
        if (verdicts_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          want = verdicts_q.pop_front();
          if (hit_o !== want.hit) begin
            $error("hit: expected %0b actual %0b", want.hit, hit_o);
            errors++;
          end
          if (outcome_o !== want.outcome) begin
            $error("outcome: expected %0d actual %0d", want.outcome, outcome_o);
            errors++;
          end
          if (hit_o === 1'b1) hits_seen++;
        end
      end
      if (hold_off > 0) begin
        stall_i <= 1'b1;
        hold_off <= hold_off - 1;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_i <= 1'b1;
        hold_off <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                  : $urandom_range(0, 2);
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else if (stim_done && verdicts_q.size() == 0) begin
      repeat (20) @(posedge clk_i);
      $display("covered %0d queries, %0d results, %0d hits", sent, results_seen,
               hits_seen);
      $display("outcomes zero/miss/outside/hit: %0d/%0d/%0d/%0d",
               cnt[0], cnt[1], cnt[2], cnt[3]);
      if (errors == 0 && verdicts_q.size() == 0 && !valid_o)
        $display("[ OK ] regression clean");
      else
        $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
